FILE: src/spmt_pkg.sv
package spmt_pkg;

   localparam int NUM_STATIONS = 16;
   localparam int MAX_SAMPLES  = 32;

   localparam int IDX_W   = $clog2(NUM_STATIONS);
   localparam int SAMP_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int MEM_AW  = IDX_W + SAMP_W;
   localparam int ADDR_W  = 48;
   localparam int POWER_W = 8;
   localparam int AGE_W   = 8;
   localparam int COUNT_OUT_W = 6;

   localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 8'd10;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic KIND_MEDIAN  = 1'b0;
   localparam logic KIND_REMOVED = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PLACE,
      ST_INS_CHK,
      ST_INS_STEP,
      ST_INS_CMP,
      ST_TK_CHK,
      ST_TK_EMIT
   } spmt_state_type;

   typedef struct packed {
      logic load_item;
      logic srch_step;
      logic place;
      logic ins_init;
      logic ins_step;
      logic ins_cmp;
      logic tk_chk;
      logic tk_emit;
   } spmt_cmd_type;

   typedef struct packed {
      logic srch_done;
      logic place_ok;
      logic store_full;
      logic j_zero;
      logic shift_up;
      logic tk_rep;
      logic idx_last;
      logic out_free;
   } spmt_status_type;

endpackage

FILE: src/station_power_median_tracker.sv
// Station power median tracker.
// Request channel (req_valid / req_stall): req_cmd selects a power sample
// for req_station_address with req_sample_power, or a publish tick. The
// block stalls requests while one item is in work.
// A sample item walks the 16-entry station table one entry a cycle,
// then inserts into that station's sorted list in the sample store, with a
// read step and a compare-and-write step per stored value moved.
// It gives no result.
// A tick walks the table one entry a cycle; each reporting entry takes an
// extra emit step after its median read and puts one item on the response
// channel (rsp_valid / rsp_stall), rsp_last marking the final one. A stalled
// receiver holds the walk at the reporting entry, while the output register
// keeps its item.
// csr_wr_en / csr_wr_data write age_limit; the user writes it only while the
// block is idle (not enforced). Synchronous reset empties the table and sets
// age_limit to 10; the sample store needs no clearing.
module station_power_median_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [spmt_pkg::ADDR_W-1:0]         req_station_address,
   input  logic signed [spmt_pkg::POWER_W-1:0] req_sample_power,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_report_kind,
   output logic [spmt_pkg::ADDR_W-1:0]         rsp_station_address_res,
   output logic signed [spmt_pkg::POWER_W-1:0] rsp_median_power,
   output logic [spmt_pkg::COUNT_OUT_W-1:0]    rsp_sample_count,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic [spmt_pkg::AGE_W-1:0]          csr_wr_data
);
   import spmt_pkg::*;

   spmt_cmd_type    cmd;
   spmt_status_type sts;

   spmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   spmt_dpath u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .sts                     (sts),
      .req_station_address     (req_station_address),
      .req_sample_power        (req_sample_power),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_report_kind         (rsp_report_kind),
      .rsp_station_address_res (rsp_station_address_res),
      .rsp_median_power        (rsp_median_power),
      .rsp_sample_count        (rsp_sample_count),
      .rsp_last                (rsp_last)
   );

endmodule

FILE: src/spmt_ctrl.sv
module spmt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_cmd,
   output logic                     req_stall,
   input  spmt_pkg::spmt_status_type sts,
   output spmt_pkg::spmt_cmd_type    cmd
);
   import spmt_pkg::*;

   spmt_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_cmd == CMD_TICK) ? ST_TK_CHK : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (sts.srch_done) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE:    state_in = sts.place_ok ? ST_INS_CHK : ST_IDLE;
         ST_INS_CHK:  state_in = sts.store_full ? ST_IDLE : ST_INS_STEP;
         ST_INS_STEP: state_in = sts.j_zero ? ST_IDLE : ST_INS_CMP;
         ST_INS_CMP:  state_in = sts.shift_up ? ST_INS_STEP : ST_IDLE;
         ST_TK_CHK: begin
            if (sts.tk_rep) begin
               state_in = ST_TK_EMIT;
            end else if (sts.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_TK_EMIT: begin
            if (sts.out_free) begin
               state_in = sts.idx_last ? ST_IDLE : ST_TK_CHK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.load_item = req_valid;
         end
         ST_SEARCH:   cmd.srch_step = 1'b1;
         ST_PLACE:    cmd.place     = 1'b1;
         ST_INS_CHK:  cmd.ins_init  = !sts.store_full;
         ST_INS_STEP: cmd.ins_step  = 1'b1;
         ST_INS_CMP:  cmd.ins_cmp   = 1'b1;
         ST_TK_CHK:   cmd.tk_chk    = 1'b1;
         ST_TK_EMIT:  cmd.tk_emit   = sts.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: src/spmt_dpath.sv
module spmt_dpath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  spmt_pkg::spmt_cmd_type                  cmd,
   output spmt_pkg::spmt_status_type               sts,
   input  logic [spmt_pkg::ADDR_W-1:0]             req_station_address,
   input  logic signed [spmt_pkg::POWER_W-1:0]     req_sample_power,
   input  logic                                    csr_wr_en,
   input  logic [spmt_pkg::AGE_W-1:0]              csr_wr_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_report_kind,
   output logic [spmt_pkg::ADDR_W-1:0]             rsp_station_address_res,
   output logic signed [spmt_pkg::POWER_W-1:0]     rsp_median_power,
   output logic [spmt_pkg::COUNT_OUT_W-1:0]        rsp_sample_count,
   output logic                                    rsp_last
);
   import spmt_pkg::*;

   logic [AGE_W-1:0]              age_ff;
   logic [ADDR_W-1:0]             item_addr_ff;
   logic signed [POWER_W-1:0]     item_pow_ff;
   logic [IDX_W-1:0]              idx_ff, slot_ff, free_ff;
   logic                          found_ff, free_ok_ff;
   logic [SAMP_W-1:0]             j_ff;

   logic [NUM_STATIONS-1:0]       valid_ff;
   logic [ADDR_W-1:0]             addr_ff   [NUM_STATIONS];
   logic [CNT_W-1:0]              cnt_ff    [NUM_STATIONS];
   logic [AGE_W-1:0]              silent_ff [NUM_STATIONS];

   logic signed [POWER_W-1:0]     mem [NUM_STATIONS << SAMP_W];
   logic signed [POWER_W-1:0]     rd_data_ff;
   logic [MEM_AW-1:0]             rd_addr, wr_addr;
   logic signed [POWER_W-1:0]     wr_data;
   logic                          rd_en, wr_en;

   logic                          rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [ADDR_W-1:0]             rsp_addr_ff;
   logic signed [POWER_W-1:0]     rsp_med_ff;
   logic [COUNT_OUT_W-1:0]        rsp_cnt_ff;

   logic [NUM_STATIONS-1:0]       rep, above;
   logic [AGE_W-1:0]              sat [NUM_STATIONS];
   logic [CNT_W-1:0]              cur_cnt, nm1;
   logic [SAMP_W-1:0]             med_idx;
   logic                          match_now, out_free, later_rep;

   always_comb begin
      for (int k = 0; k < NUM_STATIONS; k++) begin
         sat[k]   = (silent_ff[k] == '1) ? silent_ff[k] : silent_ff[k] + 1'b1;
         rep[k]   = valid_ff[k] && ((cnt_ff[k] != '0) || (sat[k] > age_ff));
         above[k] = (IDX_W'(k) > idx_ff);
      end
   end

   assign later_rep = |(rep & above);
   assign cur_cnt   = cnt_ff[idx_ff];
   assign nm1       = cur_cnt - 1'b1;
   assign med_idx   = SAMP_W'(nm1 >> 1);
   assign match_now = valid_ff[idx_ff] && (addr_ff[idx_ff] == item_addr_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      sts            = '0;
      sts.idx_last   = (idx_ff == IDX_W'(NUM_STATIONS - 1));
      sts.srch_done  = match_now || sts.idx_last;
      sts.place_ok   = found_ff || free_ok_ff;
      sts.store_full = (cnt_ff[slot_ff] >= CNT_W'(MAX_SAMPLES));
      sts.j_zero     = (j_ff == '0);
      sts.shift_up   = (rd_data_ff >= item_pow_ff);
      sts.tk_rep     = rep[idx_ff];
      sts.out_free   = out_free;
   end

   // sample store port selection
   always_comb begin
      rd_en   = 1'b0;
      wr_en   = 1'b0;
      rd_addr = {slot_ff, j_ff - 1'b1};
      wr_addr = {slot_ff, j_ff};
      wr_data = item_pow_ff;
      if (cmd.ins_step) begin
         rd_en = !sts.j_zero;
         wr_en = sts.j_zero;
      end
      if (cmd.ins_cmp) begin
         wr_en   = 1'b1;
         wr_data = sts.shift_up ? rd_data_ff : item_pow_ff;
      end
      if (cmd.tk_chk) begin
         rd_en   = 1'b1;
         rd_addr = {idx_ff, med_idx};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_addr_ff <= req_station_address;
         item_pow_ff  <= req_sample_power;
      end
      if (cmd.ins_init) begin
         j_ff <= SAMP_W'(cnt_ff[slot_ff]);
      end
      if (cmd.ins_cmp && sts.shift_up) begin
         j_ff <= j_ff - 1'b1;
      end
      if (cmd.srch_step && match_now && !found_ff) begin
         slot_ff <= idx_ff;
      end
      if (cmd.srch_step && !valid_ff[idx_ff] && !free_ok_ff) begin
         free_ff <= idx_ff;
      end
      if (cmd.place && !found_ff) begin
         slot_ff <= free_ff;
      end
      if (cmd.tk_emit) begin
         rsp_kind_ff <= (cur_cnt != '0) ? KIND_MEDIAN : KIND_REMOVED;
         rsp_addr_ff <= addr_ff[idx_ff];
         rsp_med_ff  <= (cur_cnt != '0) ? rd_data_ff : '0;
         rsp_cnt_ff  <= COUNT_OUT_W'(cur_cnt);
         rsp_last_ff <= !later_rep;
      end
      if (cmd.place && !found_ff && free_ok_ff) begin
         addr_ff[free_ff] <= item_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff       <= AGE_LIMIT_RESET;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         free_ok_ff   <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_STATIONS; k++) begin
            cnt_ff[k]    <= '0;
            silent_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            age_ff <= csr_wr_data;
         end
         if (cmd.load_item) begin
            idx_ff     <= '0;
            found_ff   <= 1'b0;
            free_ok_ff <= 1'b0;
         end
         if (cmd.srch_step) begin
            idx_ff <= idx_ff + 1'b1;
            if (match_now) begin
               found_ff <= 1'b1;
            end
            if (!valid_ff[idx_ff]) begin
               free_ok_ff <= 1'b1;
            end
         end
         // allocate a fresh entry for an unknown station
         if (cmd.place && !found_ff && free_ok_ff) begin
            valid_ff[free_ff]  <= 1'b1;
            cnt_ff[free_ff]    <= '0;
            silent_ff[free_ff] <= '0;
         end
         if ((cmd.ins_step && sts.j_zero) || (cmd.ins_cmp && !sts.shift_up)) begin
            cnt_ff[slot_ff] <= cnt_ff[slot_ff] + 1'b1;
         end
         if (cmd.tk_chk && !rep[idx_ff]) begin
            idx_ff <= idx_ff + 1'b1;
            if (valid_ff[idx_ff]) begin
               silent_ff[idx_ff] <= sat[idx_ff];
            end
         end
         if (cmd.tk_emit) begin
            idx_ff            <= idx_ff + 1'b1;
            silent_ff[idx_ff] <= '0;
            cnt_ff[idx_ff]    <= '0;
            if (cur_cnt == '0) begin
               valid_ff[idx_ff] <= 1'b0;
            end
         end
         if (cmd.tk_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_report_kind         = rsp_kind_ff;
   assign rsp_station_address_res = rsp_addr_ff;
   assign rsp_median_power        = rsp_med_ff;
   assign rsp_sample_count        = rsp_cnt_ff;
   assign rsp_last                = rsp_last_ff;

endmodule

FILE: sim/spmt_checker.sv
module spmt_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [spmt_pkg::ADDR_W-1:0]         req_station_address,
   input  logic signed [spmt_pkg::POWER_W-1:0] req_sample_power,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_report_kind,
   input  logic [spmt_pkg::ADDR_W-1:0]         rsp_station_address_res,
   input  logic signed [spmt_pkg::POWER_W-1:0] rsp_median_power,
   input  logic [spmt_pkg::COUNT_OUT_W-1:0]    rsp_sample_count,
   input  logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic [spmt_pkg::AGE_W-1:0]          csr_wr_data,
   output int                                  error_count,
   output int                                  reports_pending
);
   import spmt_pkg::*;

   typedef struct packed {
      logic                      kind;
      logic [ADDR_W-1:0]         addr;
      logic signed [POWER_W-1:0] median;
      logic [COUNT_OUT_W-1:0]    count;
      logic                      last;
   } report_type;

   report_type                report_q[$];
   logic [AGE_W-1:0]          silence_limit;
   logic [ADDR_W-1:0]         st_addr[NUM_STATIONS];
   logic                      st_used[NUM_STATIONS];
   int                        st_count[NUM_STATIONS];
   logic [7:0]                st_quiet[NUM_STATIONS];
   logic signed [POWER_W-1:0] st_powers[NUM_STATIONS][MAX_SAMPLES];

   assign reports_pending = report_q.size();

   task automatic insert_power(input logic [ADDR_W-1:0] a, input logic signed [POWER_W-1:0] p);
      int slot;
      int free_slot;
      int pos;
      slot = -1;
      free_slot = -1;
      for (int i = 0; i < NUM_STATIONS; i++) begin
         if (st_used[i]) begin
            if (st_addr[i] == a && slot < 0) slot = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (slot < 0) begin
         if (free_slot < 0) return;
         slot = free_slot;
         st_used[slot] = 1'b1;
         st_addr[slot] = a;
         st_count[slot] = 0;
         st_quiet[slot] = 0;
      end
      if (st_count[slot] >= MAX_SAMPLES) return;
      pos = 0;
      while (pos < st_count[slot] && st_powers[slot][pos] < p) pos++;
      for (int j = st_count[slot]; j > pos; j--) st_powers[slot][j] = st_powers[slot][j-1];
      st_powers[slot][pos] = p;
      st_count[slot]++;
   endtask

   task automatic publish_tick();
      report_type r;
      int         first;
      first = report_q.size();
      for (int i = 0; i < NUM_STATIONS; i++) begin
         if (!st_used[i]) continue;
         if (st_count[i] > 0) begin
            r = '{KIND_MEDIAN, st_addr[i], st_powers[i][(st_count[i]-1)/2],
                  COUNT_OUT_W'(st_count[i]), 1'b0};
            report_q.push_back(r);
            st_count[i] = 0;
            st_quiet[i] = 0;
         end else begin
            if (st_quiet[i] != 8'd255) st_quiet[i]++;
            if (st_quiet[i] > silence_limit) begin
               r = '{KIND_REMOVED, st_addr[i], '0, '0, 1'b0};
               report_q.push_back(r);
               st_used[i] = 1'b0;
               st_quiet[i] = 0;
            end
         end
      end
      if (report_q.size() > first) report_q[report_q.size()-1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      report_type got;
      report_type want;
      if (reset) begin
         silence_limit <= AGE_LIMIT_RESET;
         for (int i = 0; i < NUM_STATIONS; i++) begin
            st_used[i] = 1'b0;
            st_count[i] = 0;
            st_quiet[i] = 0;
         end
         report_q.delete();
         error_count <= 0;
      end else begin
         if (csr_wr_en) silence_limit <= csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_report_kind, rsp_station_address_res, rsp_median_power,
                    rsp_sample_count, rsp_last};
            if (report_q.size() == 0) begin
               error_count <= error_count + 1;
               if (error_count < 10) $display("unexpected report %p", got);
            end else begin
               want = report_q.pop_front();
               if (got !== want) begin
                  error_count <= error_count + 1;
                  if (error_count < 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_cmd == CMD_SAMPLE) insert_power(req_station_address, req_sample_power);
            else publish_tick();
         end
      end
   end
endmodule

FILE: sim/tb_station_power_median_tracker.sv
module tb_station_power_median_tracker;
   import spmt_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_cmd = CMD_SAMPLE;
   logic [ADDR_W-1:0]         req_station_address = '0;
   logic signed [POWER_W-1:0] req_sample_power = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_report_kind;
   logic [ADDR_W-1:0]         rsp_station_address_res;
   logic signed [POWER_W-1:0] rsp_median_power;
   logic [COUNT_OUT_W-1:0]    rsp_sample_count;
   logic                      rsp_last;
   logic                      csr_wr_en = 1'b0;
   logic [AGE_W-1:0]          csr_wr_data = '0;
   int                        error_count;
   int                        reports_pending;
   int                        cycle_count = 0;
   logic                      calm = 1'b0;
   logic                      hold_off = 1'b0;
   logic [ADDR_W-1:0]         known_addr[24];

   station_power_median_tracker dut (.*);

   spmt_checker checker_i (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 900000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver stalls at random, or for a long stretch when asked
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
         repeat (400) @(negedge clock);
         rsp_stall <= 1'b0;
         wait (!hold_off);
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 12);
      end
   end

   // valid stays high across back-to-back items; drop it only to idle
   task automatic send_item(input logic c, input logic [ADDR_W-1:0] a,
                            input logic signed [POWER_W-1:0] p);
      while (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_station_address <= a;
      req_sample_power <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_age(input logic [AGE_W-1:0] v);
      req_valid <= 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (120) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(input int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 10)
            send_item(CMD_TICK, ADDR_W'({$urandom, $urandom}), POWER_W'($urandom));
         else if (k < 85)
            send_item(CMD_SAMPLE, known_addr[$urandom_range(23)], POWER_W'($urandom));
         else
            send_item(CMD_SAMPLE, ADDR_W'({$urandom, $urandom}), POWER_W'($urandom));
      end
   endtask

   initial begin
      foreach (known_addr[i]) known_addr[i] = ADDR_W'({$urandom, $urandom});
      known_addr[0] = '0;
      known_addr[1] = '1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      // directed: extremes, equal powers, empty tick, full table
      send_item(CMD_TICK, '0, '0);
      send_item(CMD_SAMPLE, known_addr[0], -8'sd128);
      send_item(CMD_SAMPLE, known_addr[0], 8'sd127);
      send_item(CMD_SAMPLE, known_addr[0], 8'sd127);
      send_item(CMD_SAMPLE, known_addr[0], 8'sd0);
      send_item(CMD_SAMPLE, known_addr[1], -8'sd1);
      send_item(CMD_TICK, '1, '1);
      for (int i = 0; i < 18; i++) send_item(CMD_SAMPLE, known_addr[2 + i], 8'sd5);
      send_item(CMD_TICK, '0, '0);
      write_age(8'd0);
      send_item(CMD_TICK, '0, '0);
      send_item(CMD_TICK, '0, '0);
      // fill one sample store past its limit
      for (int i = 0; i < 36; i++) send_item(CMD_SAMPLE, known_addr[3], POWER_W'($urandom));
      send_item(CMD_TICK, '0, '0);
      write_age(8'd255);
      random_phase(60);
      send_item(CMD_TICK, '0, '0);
      random_phase(10);
      // long receiver hold-off while items keep coming
      hold_off <= 1'b1;
      send_item(CMD_SAMPLE, known_addr[3], 8'sd7);
      send_item(CMD_TICK, '0, '0);
      send_item(CMD_SAMPLE, known_addr[3], -8'sd7);
      send_item(CMD_TICK, '0, '0);
      send_item(CMD_TICK, '0, '0);
      hold_off <= 1'b0;
      write_age(8'd2);
      calm <= 1'b1;
      random_phase(50);
      calm <= 1'b0;
      random_phase(40);
      write_age(8'd254);
      random_phase(30);
      write_age(8'd1);
      random_phase(30);
      for (int i = 0; i < 4; i++) send_item(CMD_TICK, '0, '0);
      req_valid <= 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
